// File: design/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry block.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF  = 24;
    localparam int POS_FRAC_BITS_DEF = 16;

    // Operand and product widths of the shared multiplier
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Divisor and quotient widths of the shared divider
    localparam int DIV_DW = 50;
    localparam int DIV_QW = 34;

    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    localparam logic [19:0] MICRO_SCALE = 20'd1000000;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [33:0] ONE_Q30     = 34'd1073741824;

    localparam logic [19:0] RADIUS_RST = 20'd32500;
    localparam logic [23:0] WBASE_RST  = 24'd150000;
    localparam logic [9:0]  GEAR_RST   = 10'd1;
    localparam logic [15:0] CPR_RST    = 16'd1024;
    localparam logic [22:0] MAXD_RST   = 23'd10000;

    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_WBASE  = 3'd1;
    localparam logic [2:0] CFG_GEAR   = 3'd2;
    localparam logic [2:0] CFG_CPR    = 3'd3;
    localparam logic [2:0] CFG_MAXD   = 3'd4;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_IMPLAUS = 2'd1,
        ST_ZERODIV = 2'd2,
        ST_POSESET = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REQ_UPDATE  = 1'b0,
        REQ_SETPOSE = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [23:0] left_delta;
        logic signed [23:0] right_delta;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_heading;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] heading;
        logic signed [31:0] heading_cos;
        logic signed [31:0] heading_sin;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_GC,
        S_D1,
        S_A1,
        S_PLO,
        S_PHI,
        S_D2,
        S_A2,
        S_DIV1,
        S_DIV1W,
        S_DIV2W,
        S_MIDC,
        S_CMIDW,
        S_MX,
        S_MY,
        S_UPD,
        S_CSTART,
        S_COUTW,
        S_FIN
    } t_state;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/ddo_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module ddo_mul (
    input  wire                             i_clk,
    input  wire  [ddo_pkg::MUL_W-1:0]       i_a,
    input  wire  [ddo_pkg::MUL_W-1:0]       i_b,
    output logic [ddo_pkg::PROD_W-1:0]      o_p
);
    import ddo_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// File: design/ddo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ddo_div #(
    parameter int NW = 95
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [NW-1:0]                i_num,
    input  wire  [ddo_pkg::DIV_DW-1:0]   i_den,
    input  wire  [$clog2(NW+1)-1:0]      i_steps,
    output logic                         o_done,
    output logic [ddo_pkg::DIV_QW-1:0]   o_quo,
    output logic                         o_ovf
);
    import ddo_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic              r_busy, r_done, r_ovf;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_sh;
    logic [DIV_DW-1:0] r_rem, r_den;
    logic [DIV_QW-1:0] r_q;

    logic [DIV_DW:0]   rt;
    logic              ge;

    always_comb begin
        rt = {r_rem, r_sh[NW-1]};
        ge = rt >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_sh   <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_sh  <= {r_sh[NW-2:0], 1'b0};
                r_rem <= ge ? DIV_DW'(rt - {1'b0, r_den}) : DIV_DW'(rt);
                r_q   <= {r_q[DIV_QW-2:0], ge};
                // quotient bits that drop off the top mean the result is out of range
                r_ovf <= r_ovf | r_q[DIV_QW-1];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

// File: design/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle in Q1.30.
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [31:0]         i_angle,
    output logic                o_done,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin
);
    import ddo_pkg::*;

    localparam int IW = $clog2(STEPS + 1);

    logic               r_busy, r_done, r_flip;
    logic [IW-1:0]      r_i;
    logic signed [33:0] r_x, r_y, r_z;

    logic [31:0]        a_rot, a_fold;
    logic               flip;
    logic signed [33:0] dx, dy, at, xf, yf;

    always_comb begin
        a_rot  = i_angle + 32'h4000_0000;
        flip   = a_rot[31];
        a_fold = flip ? (i_angle + 32'h8000_0000) : i_angle;
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        at     = signed'({2'b00, atan_val(5'(r_i))});
        xf     = r_flip ? -r_x : r_x;
        yf     = r_flip ? -r_y : r_y;
        if (xf > signed'(ONE_Q30))       o_cos = 32'(ONE_Q30);
        else if (xf < -signed'(ONE_Q30)) o_cos = 32'(-signed'(ONE_Q30));
        else                             o_cos = 32'(xf);
        if (yf > signed'(ONE_Q30))       o_sin = 32'(ONE_Q30);
        else if (yf < -signed'(ONE_Q30)) o_sin = 32'(-signed'(ONE_Q30));
        else                             o_sin = 32'(yf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_flip <= flip;
                r_x    <= signed'(CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= 34'(signed'(a_fold));
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_i <= r_i + IW'(1);
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// File: design/diff_drive_odometry.sv
// Top level: sequencer, configuration, pose state and result register.
// Encoder update: two passes of the bit-serial divider and two CORDIC runs lie between input
//   transfer and valid result; a set pose or rejected update needs one CORDIC run only.
// Both wait for a free output register before the result is registered.
//   One item at a time; the next item can be taken in the cycle after the result is registered.
// Reset (synchronous, active low) clears the pose and loads default configuration.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry #(
    parameter int CORDIC_STEPS  = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  ddo_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ddo_pkg::t_rsp      o_out_data,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [23:0]        i_cfg_data
);
    import ddo_pkg::*;

    localparam int NW = 79 + POS_FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    t_state r_state, n_state;

    logic [19:0] r_radius;
    logic [23:0] r_wbase;
    logic [9:0]  r_gear;
    logic [15:0] r_cpr;
    logic [22:0] r_maxd;

    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_head;

    t_req    r_req;
    t_status r_status;
    t_rsp    r_out;
    logic    r_ovalid;

    logic [24:0] r_sabs, r_dabs;
    logic        r_sneg, r_fneg;
    logic [25:0] r_gc;
    logic [45:0] r_den1;
    logic [44:0] r_a1, r_a2;
    logic [78:0] r_num;
    logic [49:0] r_den2;
    logic [32:0] r_dcm;
    logic [31:0] r_full, r_half;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic              div_start, div_done, div_ovf;
    logic [NW-1:0]     div_num;
    logic [DIV_DW-1:0] div_den;
    logic [CW-1:0]     div_steps;
    logic [DIV_QW-1:0] div_q;
    logic              cor_start, cor_done;
    logic [31:0]       cor_angle;
    logic signed [31:0] cor_cos, cor_sin;

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ddo_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_ovf   (div_ovf)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // decode of the held request
    logic [23:0] lmag, rmag;
    logic [24:0] dsum, ddif;
    logic        implaus, zdiv, out_free;

    always_comb begin
        lmag    = r_req.left_delta[23]  ? 24'(-r_req.left_delta)  : r_req.left_delta;
        rmag    = r_req.right_delta[23] ? 24'(-r_req.right_delta) : r_req.right_delta;
        dsum    = 25'(signed'(r_req.left_delta)) + 25'(signed'(r_req.right_delta));
        ddif    = 25'(signed'(r_req.right_delta)) - 25'(signed'(r_req.left_delta));
        implaus = (lmag > {1'b0, r_maxd}) || (rmag > {1'b0, r_maxd});
        zdiv    = (r_gear == '0) || (r_cpr == '0) || (r_wbase == '0);
        out_free = !r_ovalid || !i_out_stall;
    end

    // centre travel from the first quotient, heading steps from the second
    logic [33:0] qp1, qp2;
    logic [33:0] dc_rnd;
    logic [31:0] full_m, half_m;

    always_comb begin
        dc_rnd = 34'(div_q[DIV_QW-1:1]) + 34'(div_q[0]);
        qp1    = div_q + 34'd1;
        qp2    = div_q + 34'd2;
        full_m = qp1[32:1];
        half_m = qp2[33:2];
    end

    // rounded position step and saturating add
    logic [63:0]        prnd;
    logic [32:0]        step_m;
    logic               cneg, sneg_t, step_neg;
    logic signed [34:0] step_s, pos_sum;
    logic signed [31:0] pos_old, pos_new;

    always_comb begin
        prnd     = prod[63:0] + 64'h2000_0000;
        step_m   = prnd[62:30];
        cneg     = cor_cos[31];
        sneg_t   = cor_sin[31];
        step_neg = r_sneg ^ ((r_state == S_MY) ? cneg : sneg_t);
        step_s   = step_neg ? -signed'({2'b00, step_m}) : signed'({2'b00, step_m});
        pos_old  = (r_state == S_MY) ? r_x : r_y;
        pos_sum  = 35'(pos_old) + step_s;
        if (pos_sum > 35'sd2147483647)       pos_new = 32'sh7FFF_FFFF;
        else if (pos_sum < -35'sd2147483648) pos_new = 32'sh8000_0000;
        else                                 pos_new = 32'(pos_sum);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_req.req_type == REQ_SETPOSE || implaus || zdiv) n_state = S_CSTART;
                else                                                   n_state = S_GC;
            end
            S_GC:     n_state = S_D1;
            S_D1:     n_state = S_A1;
            S_A1:     n_state = S_PLO;
            S_PLO:    n_state = S_PHI;
            S_PHI:    n_state = S_D2;
            S_D2:     n_state = S_A2;
            S_A2:     n_state = S_DIV1;
            S_DIV1:   n_state = S_DIV1W;
            S_DIV1W:  if (div_done) n_state = S_DIV2W;
            S_DIV2W:  if (div_done) n_state = S_MIDC;
            S_MIDC:   n_state = S_CMIDW;
            S_CMIDW:  if (cor_done) n_state = S_MX;
            S_MX:     n_state = S_MY;
            S_MY:     n_state = S_UPD;
            S_UPD:    n_state = S_CSTART;
            S_CSTART: n_state = S_COUTW;
            S_COUTW:  if (cor_done) n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = {r_num, {POS_FRAC_BITS{1'b0}}};
        div_den   = DIV_DW'(r_den1);
        div_steps = CW'(NW - 31);
        cor_start = 1'b0;
        cor_angle = r_head;
        unique case (r_state)
            S_GC:  begin mul_a = MUL_W'(r_gear);      mul_b = MUL_W'(r_cpr);       end
            S_D1:  begin mul_a = MUL_W'(prod[25:0]);  mul_b = MUL_W'(MICRO_SCALE); end
            S_A1:  begin mul_a = MUL_W'(r_radius);    mul_b = MUL_W'(r_sabs);      end
            S_PLO: begin mul_a = MUL_W'(prod[31:0]);  mul_b = PI_Q32;              end
            S_PHI: begin mul_a = MUL_W'(r_a1[44:32]); mul_b = PI_Q32;              end
            S_D2:  begin mul_a = MUL_W'(r_gc);        mul_b = MUL_W'(r_wbase);     end
            S_A2:  begin mul_a = MUL_W'(r_radius);    mul_b = MUL_W'(r_dabs);      end
            S_DIV1: div_start = 1'b1;
            S_DIV1W: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = {r_a2, {(NW - 45){1'b0}}};
                    div_den   = r_den2;
                    div_steps = CW'(78);
                end
            end
            S_MIDC: begin
                cor_start = 1'b1;
                cor_angle = r_head + r_half;
            end
            S_MX: begin
                mul_a = MUL_W'(r_dcm);
                mul_b = MUL_W'(cneg ? 32'(-cor_cos) : cor_cos);
            end
            S_MY: begin
                mul_a = MUL_W'(r_dcm);
                mul_b = MUL_W'(sneg_t ? 32'(-cor_sin) : cor_sin);
            end
            S_CSTART: cor_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
            r_radius <= RADIUS_RST;
            r_wbase  <= WBASE_RST;
            r_gear   <= GEAR_RST;
            r_cpr    <= CPR_RST;
            r_maxd   <= MAXD_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data[19:0];
                    CFG_WBASE:  r_wbase  <= i_cfg_data;
                    CFG_GEAR:   r_gear   <= i_cfg_data[9:0];
                    CFG_CPR:    r_cpr    <= i_cfg_data[15:0];
                    CFG_MAXD:   r_maxd   <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (r_state == S_FIN && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall)            r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_req <= i_in_data;
                S_DECIDE: begin
                    r_sabs <= dsum[24] ? 25'(-dsum) : dsum;
                    r_dabs <= ddif[24] ? 25'(-ddif) : ddif;
                    r_sneg <= dsum[24];
                    r_fneg <= ddif[24];
                    if (r_req.req_type == REQ_SETPOSE) begin
                        r_x      <= r_req.new_x;
                        r_y      <= r_req.new_y;
                        r_head   <= r_req.new_heading;
                        r_status <= ST_POSESET;
                    end else if (implaus) begin
                        r_status <= ST_IMPLAUS;
                    end else if (zdiv) begin
                        r_status <= ST_ZERODIV;
                    end else begin
                        r_status <= ST_UPDATED;
                    end
                end
                S_D1:  r_gc   <= prod[25:0];
                S_A1:  r_den1 <= prod[45:0];
                S_PLO: r_a1   <= prod[44:0];
                S_PHI: r_num  <= 79'(prod[65:0]);
                S_D2:  r_num  <= r_num + {prod[46:0], 32'd0};
                S_A2:  r_den2 <= prod[49:0];
                S_DIV1: r_a2  <= prod[44:0];
                S_DIV1W: begin
                    if (div_done) begin
                        r_dcm <= (div_ovf || dc_rnd > 34'h1_0000_0000) ?
                                 33'h1_0000_0000 : 33'(dc_rnd);
                    end
                end
                S_DIV2W: begin
                    if (div_done) begin
                        r_full <= r_fneg ? -full_m : full_m;
                        r_half <= r_fneg ? -half_m : half_m;
                    end
                end
                S_MY:  r_x    <= pos_new;
                S_UPD: begin
                    r_y    <= pos_new;
                    r_head <= r_head + r_full;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.status      <= r_status;
                        r_out.pose_x      <= r_x;
                        r_out.pose_y      <= r_y;
                        r_out.heading     <= r_head;
                        r_out.heading_cos <= cor_cos;
                        r_out.heading_sin <= cor_sin;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire
